// File: design/tcw_pkg.sv
`timescale 1ns / 1ps
// tcw_pkg: shared types and constants for the text console writer
// holds request codes, command and state enums, field widths and defaults
// no dependencies
package tcw_pkg;

	// default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;
	localparam int QUEUE_DEPTH = 4;

	// field widths fixed by the ports
	localparam int CHAR_W       = 8;
	localparam int IDX_W        = 11;
	localparam int CELL_W       = 16;
	localparam int CURSOR_ROW_W = 5;
	localparam int CURSOR_COL_W = 7;

	// request codes on req_type
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// special bytes and reset attribute
	localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'h0a;
	localparam logic [CHAR_W-1:0] SPACE_BYTE   = 8'h20;
	localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h07;

	// classified command carried through the queue
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_NEWLINE,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_DRAIN,
		ST_BLANK,
		ST_CLEAR
	} eng_state_t;

endpackage

// File: design/tcw_front.sv
`timescale 1ns / 1ps
// tcw_front: input channel and request classifier of the text console writer
// depends on tcw_pkg for request codes and the command type
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
	input  logic                      queue_full,
	input  logic                      init_busy,
	output logic                      push,
	output tcw_pkg::cmd_t             cmd
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	logic in_range;

	// stall while the queue is full or the store is being cleared after reset
	assign in_stall = queue_full | init_busy;
	assign push     = in_valid & ~in_stall;
	assign in_range = (32'(cell_index) < 32'(CELLS));

	// classify the request
	always_comb begin
		cmd.ch  = char_code;
		cmd.idx = cell_index;
		unique case (req_type)
			REQ_PUT:   cmd.op = (char_code == NEWLINE_BYTE) ? OP_NEWLINE : OP_PUT;
			REQ_READ:  cmd.op = in_range ? OP_READ : OP_NOP;
			REQ_CLEAR: cmd.op = OP_CLEAR;
			default:   cmd.op = OP_NOP;
		endcase
	end

endmodule

// File: design/tcw_fifo.sv
`timescale 1ns / 1ps
// tcw_fifo: short command queue between the classifier and the sequencer
// depends on tcw_pkg for the command type
module tcw_fifo #(
	parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_data,
	input  logic          pop,
	output tcw_pkg::cmd_t pop_data,
	output logic          empty,
	output logic          full
);
	import tcw_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign pop_data = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: design/tcw_engine.sv
`timescale 1ns / 1ps
// tcw_engine: screen store, cursor and sequencer of the text console writer
// carries out queued commands, sweeps the store for clear, scroll and reset
// depends on tcw_pkg for the command type, states and constants
module tcw_engine #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tcw_pkg::CHAR_W-1:0]       cfg_wr_data,
	input  tcw_pkg::cmd_t                   cmd,
	input  logic                            cmd_valid,
	output logic                            cmd_pop,
	output logic                            init_busy,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcw_pkg::CELL_W-1:0]       cell_data,
	output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
	output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col
);
	import tcw_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ROW_XW = (ROW_W > CURSOR_ROW_W) ? ROW_W : CURSOR_ROW_W;
	localparam int COL_XW = (COL_W > CURSOR_COL_W) ? COL_W : CURSOR_COL_W;

	localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - COLUMNS);

	eng_state_t state_q, state_d;

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata;

	logic [ADDR_W-1:0] sweep_q, sweep_start;
	logic              sweep_last;
	logic              scr_vld_s1, scr_vld_d;
	logic [ADDR_W-1:0] scr_dst_s1;

	logic [CHAR_W-1:0] attr_q;
	logic [CELL_W-1:0] blank;

	logic [ROW_W-1:0]  row_q, row_d, nr_row;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] addr_q, addr_d, base_q, base_d, nr_base;
	logic              at_last_col, at_last_row, can_pop;

	logic                    out_valid_q, out_load;
	logic [CELL_W-1:0]       out_data_q, out_data_d;
	logic [CURSOR_ROW_W-1:0] out_row_q;
	logic [CURSOR_COL_W-1:0] out_col_q;
	logic [ROW_XW-1:0]       row_dx;
	logic [COL_XW-1:0]       col_dx;

	assign blank       = {attr_q, SPACE_BYTE};
	assign sweep_last  = (sweep_q == LAST_ADDR);
	assign at_last_col = (col_q == COL_W'(COLUMNS - 1));
	assign at_last_row = (row_q == ROW_W'(ROWS - 1));
	assign can_pop     = cmd_valid & (~out_valid_q | ~out_stall);
	assign init_busy   = (state_q == ST_INIT);

	// cursor position one row down, held on the last row where the screen scrolls
	assign nr_row  = at_last_row ? row_q : row_q + 1'b1;
	assign nr_base = at_last_row ? base_q : base_q + ROW_STEP;

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: if (sweep_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (can_pop) begin
					unique case (cmd.op)
						OP_READ:    state_d = ST_READ;
						OP_CLEAR:   state_d = ST_CLEAR;
						OP_PUT:     if (at_last_col && at_last_row) state_d = ST_SCROLL;
						OP_NEWLINE: if (at_last_row) state_d = ST_SCROLL;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:   state_d = ST_IDLE;
			ST_SCROLL: if (sweep_q == LAST_ADDR) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_BLANK;
			ST_BLANK:  if (sweep_last) state_d = ST_IDLE;
			ST_CLEAR:  if (sweep_last) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs: store access, cursor update and result load
	always_comb begin
		cmd_pop     = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = sweep_q;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = sweep_q;
		scr_vld_d   = 1'b0;
		sweep_start = '0;
		out_load    = 1'b0;
		out_data_d  = '0;
		row_d       = row_q;
		col_d       = col_q;
		addr_d      = addr_q;
		base_d      = base_q;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				cmd_pop = can_pop;
				if (can_pop) begin
					unique case (cmd.op)
						OP_PUT: begin
							mem_we      = 1'b1;
							mem_waddr   = addr_q;
							mem_wdata   = {attr_q, cmd.ch};
							sweep_start = ROW_STEP;
							if (at_last_col) begin
								row_d    = nr_row;
								col_d    = '0;
								base_d   = nr_base;
								addr_d   = nr_base;
								out_load = ~at_last_row;
							end else begin
								col_d    = col_q + 1'b1;
								addr_d   = addr_q + 1'b1;
								out_load = 1'b1;
							end
						end
						OP_NEWLINE: begin
							sweep_start = ROW_STEP;
							row_d       = nr_row;
							col_d       = '0;
							base_d      = nr_base;
							addr_d      = nr_base;
							out_load    = ~at_last_row;
						end
						OP_READ: begin
							mem_re    = 1'b1;
							mem_raddr = ADDR_W'(cmd.idx);
						end
						OP_CLEAR: begin
							row_d  = '0;
							col_d  = '0;
							base_d = '0;
							addr_d = '0;
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				out_load   = 1'b1;
				out_data_d = rd_data_q;
			end
			ST_SCROLL: begin
				mem_re    = 1'b1;
				scr_vld_d = 1'b1;
				mem_we    = scr_vld_s1;
				mem_waddr = scr_dst_s1;
				mem_wdata = rd_data_q;
			end
			ST_DRAIN: begin
				mem_we      = scr_vld_s1;
				mem_waddr   = scr_dst_s1;
				mem_wdata   = rd_data_q;
				sweep_start = LAST_ROW_BASE;
			end
			ST_BLANK, ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = blank;
				out_load  = sweep_last;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// screen store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// scroll copy stage: destination lags the source read by one row
	always_ff @(posedge clk) begin
		scr_dst_s1 <= sweep_q - ROW_STEP;
	end

	// sequencer control registers and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			sweep_q    <= '0;
			scr_vld_s1 <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			addr_q     <= '0;
			base_q     <= '0;
		end else begin
			state_q    <= state_d;
			sweep_q    <= (state_d != state_q) ? sweep_start : sweep_q + 1'b1;
			scr_vld_s1 <= scr_vld_d;
			row_q      <= row_d;
			col_q      <= col_d;
			addr_q     <= addr_d;
			base_q     <= base_d;
		end
	end

	// result register
	assign row_dx = ROW_XW'(row_d);
	assign col_dx = COL_XW'(col_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_row_q  <= row_dx[CURSOR_ROW_W-1:0];
			out_col_q  <= col_dx[CURSOR_COL_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_data  = out_data_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load) else $error("result overwritten");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < 32'(ROWS)) else $error("cursor row out of range");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(COLUMNS)) else $error("cursor column out of range");
	a_addr_track: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q == base_q + ADDR_W'(col_q)) else $error("cursor address out of step");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop without command");
`endif

endmodule

// File: design/text_console_writer_top.sv
`timescale 1ns / 1ps
// text_console_writer_top: character-cell text console, ROWS x COLUMNS cells
// depends on tcw_pkg, tcw_front, tcw_fifo and tcw_engine
//
// usage
//   request channel (in_valid/in_stall): req_type put, read or clear, with
//   char_code and cell_index. every request gives exactly one result on the
//   result channel (out_valid/out_stall): cell_data for a read, zero otherwise,
//   and the cursor after the request.
//   cfg_wr_en/cfg_wr_data write the attribute byte; write only while idle.
// request handling
//   put, newline, no-op: one per cycle unless a held result stalls it.
//   read: via a read state (registered store read port), one at a time.
//   scroll: one store cell copied per cycle, then the bottom row blanked.
//   clear: one store cell written per cycle.
//   a 4-entry queue keeps taking requests while the sequencer is busy.
// reset
//   arst_n homes the cursor and sets the attribute to 0x07; then a pass of
//   ROWS*COLUMNS cells (2000 at 80x25) zeroes the store, in_stall held high.
// stall
//   a result waits in its register while out_stall is high; the sequencer
//   stops and the queue fills, after which in_stall rises.
module text_console_writer_top #(
	parameter int COLUMNS     = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS        = tcw_pkg::DEF_ROWS,
	parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tcw_pkg::CHAR_W-1:0]       cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcw_pkg::CELL_W-1:0]       cell_data,
	output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
	output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col
);
	import tcw_pkg::*;

	cmd_t push_cmd, head_cmd;
	logic push, pop, q_empty, q_full, init_busy;

	// request classifier
	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.char_code  (char_code),
		.cell_index (cell_index),
		.queue_full (q_full),
		.init_busy  (init_busy),
		.push       (push),
		.cmd        (push_cmd)
	);

	// command queue
	tcw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.pop_data  (head_cmd),
		.empty     (q_empty),
		.full      (q_full)
	);

	// store and cursor sequencer
	tcw_engine #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (head_cmd),
		.cmd_valid   (~q_empty),
		.cmd_pop     (pop),
		.init_busy   (init_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_data   (cell_data),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col)
	);

endmodule

// File: bench/tcw_checker.sv
`timescale 1ns / 1ps
// tcw_checker: watches the request, result and attribute ports of the text console
// keeps its own screen, cursor and attribute copy and compares every result transfer
// depends on tcw_pkg
module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tcw_pkg::CHAR_W-1:0]       cfg_wr_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [tcw_pkg::CELL_W-1:0]       cell_data,
	input  logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
	input  logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
	output int                               mismatch_count,
	output int                               results_pending,
	output int                               results_checked,
	output int                               scroll_count,
	output int                               clear_count
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [CELL_W-1:0]       cell_val;
		logic [CURSOR_ROW_W-1:0] row;
		logic [CURSOR_COL_W-1:0] col;
	} console_result_t;

	// mirrored console state
	logic [CELL_W-1:0] screen_copy [CELLS];
	int unsigned       row_now;
	int unsigned       col_now;
	logic [CHAR_W-1:0] attr_now;
	console_result_t   expected_results [$];

	int errors   = 0;
	int checked  = 0;
	int scrolls  = 0;
	int clears   = 0;

	// one line per mismatch, printing capped so a broken block stays readable
	task automatic report_mismatch(string what, logic [CELL_W-1:0] got,
			logic [CELL_W-1:0] want);
		if (errors < 50)
			$display("mismatch on %s: got 0x%h, expected 0x%h at %0t ns",
				what, got, want, $time);
		errors++;
	endtask

	// move every row up one and blank the bottom row
	task automatic scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen_copy[i] = screen_copy[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			screen_copy[i] = {attr_now, SPACE_BYTE};
		scrolls++;
	endtask

	// carriage return plus line feed, scrolling past the bottom row
	task automatic advance_row();
		col_now = 0;
		row_now++;
		if (row_now >= ROWS) begin
			scroll_screen();
			row_now = ROWS - 1;
		end
	endtask

	// update the mirror for one accepted request and queue its result
	task automatic apply_request(logic [1:0] req, logic [CHAR_W-1:0] ch,
			logic [IDX_W-1:0] idx);
		console_result_t   res;
		logic [CELL_W-1:0] data;
		data = '0;
		case (req)
			REQ_PUT: begin
				if (ch == NEWLINE_BYTE) begin
					advance_row();
				end else begin
					screen_copy[row_now * COLUMNS + col_now] = {attr_now, ch};
					col_now++;
					if (col_now >= COLUMNS)
						advance_row();
				end
			end
			REQ_READ: begin
				if (idx < CELLS)
					data = screen_copy[idx];
			end
			REQ_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_copy[i] = {attr_now, SPACE_BYTE};
				row_now = 0;
				col_now = 0;
				clears++;
			end
			default: ;
		endcase
		res.cell_val = data;
		res.row      = row_now[CURSOR_ROW_W-1:0];
		res.col      = col_now[CURSOR_COL_W-1:0];
		expected_results.push_back(res);
	endtask

	// monitor both channels and the attribute write port
	always @(posedge clk or negedge arst_n) begin : monitor
		console_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen_copy[i] = '0;
			row_now  = 0;
			col_now  = 0;
			attr_now = ATTR_RESET;
			expected_results.delete();
		end else begin
			if (cfg_wr_en)
				attr_now = cfg_wr_data;
			// a result transfer always belongs to an earlier request
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending", cell_data, '0);
				end else begin
					want = expected_results.pop_front();
					if (cell_data !== want.cell_val)
						report_mismatch("cell_data", cell_data, want.cell_val);
					if (cursor_row !== want.row)
						report_mismatch("cursor_row", CELL_W'(cursor_row), CELL_W'(want.row));
					if (cursor_col !== want.col)
						report_mismatch("cursor_col", CELL_W'(cursor_col), CELL_W'(want.col));
					checked++;
				end
			end
			if (in_valid && !in_stall)
				apply_request(req_type, char_code, cell_index);
		end
		mismatch_count  <= errors;
		results_pending <= expected_results.size();
		results_checked <= checked;
		scroll_count    <= scrolls;
		clear_count     <= clears;
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the text console writer
// drives requests, attribute writes and result back-pressure; tcw_checker does the checking
// depends on tcw_pkg, text_console_writer_top and tcw_checker
module tb_top;
	import tcw_pkg::*;

	// request code the block must ignore
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int PHASES          = 6;
	localparam int PHASE_REQUESTS  = 205;
	localparam int LONG_HOLD       = 160;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CHAR_W-1:0]       cfg_wr_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              req_type;
	logic [CHAR_W-1:0]       char_code;
	logic [IDX_W-1:0]        cell_index;
	logic                    out_valid;
	logic                    out_stall;
	logic [CELL_W-1:0]       cell_data;
	logic [CURSOR_ROW_W-1:0] cursor_row;
	logic [CURSOR_COL_W-1:0] cursor_col;

	int mismatch_count;
	int results_pending;
	int results_checked;
	int scroll_count;
	int clear_count;

	int requests_sent   = 0;
	int attribute_writes = 0;
	int long_holds      = 0;
	bit sender_calm     = 1'b0;

	always #4 clk = ~clk;

	text_console_writer_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.char_code   (char_code),
		.cell_index  (cell_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_data   (cell_data),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col)
	);

	tcw_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cell_data       (cell_data),
		.cursor_row      (cursor_row),
		.cursor_col      (cursor_col),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending),
		.results_checked (results_checked),
		.scroll_count    (scroll_count),
		.clear_count     (clear_count)
	);

	// offer one request after a random gap and hold it until the transfer
	task automatic issue_request(logic [1:0] req, logic [CHAR_W-1:0] ch,
			logic [IDX_W-1:0] idx);
		int unsigned gap;
		if (requests_sent % 64 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
		gap = sender_calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		char_code  <= ch;
		cell_index <= idx;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// mostly text with line breaks and reads, a few clears and ignored codes
	task automatic random_request();
		int unsigned       pick;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		pick = $urandom_range(0, 999);
		if ($urandom_range(0, 3) == 0)
			ch = CHAR_W'($urandom_range(0, 255));
		else
			ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
		idx = IDX_W'($urandom_range(0, 2047));
		if (pick < 600) begin
			issue_request(REQ_PUT, ch, idx);
		end else if (pick < 700) begin
			issue_request(REQ_PUT, NEWLINE_BYTE, idx);
		end else if (pick < 960) begin
			case ($urandom_range(0, 3))
				0: idx = IDX_W'($urandom_range(0, 1999));
				1: idx = IDX_W'($urandom_range(1920, 1999));
				2: idx = IDX_W'($urandom_range(0, 159));
				default: ;
			endcase
			issue_request(REQ_READ, ch, idx);
		end else if (pick < 995) begin
			issue_request(REQ_UNUSED, ch, idx);
		end else begin
			issue_request(REQ_CLEAR, ch, idx);
		end
	endtask

	// stop offering and wait until every result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// attribute write, only while the block is idle
	task automatic write_attribute(logic [CHAR_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		attribute_writes++;
	endtask

	// result side back-pressure, with calm stretches and long hold-offs
	initial begin : result_sink
		int unsigned gap;
		int          taken;
		bit          calm;
		taken = 0;
		calm  = 1'b0;
		out_stall = 1'b0;
		forever begin
			if (taken % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 14);
			if (taken == 150 || taken == 700) begin
				gap = LONG_HOLD;
				long_holds++;
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && arst_n));
			taken++;
		end
	end

	// watchdog
	initial begin
		#100_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [CHAR_W-1:0] attr_value;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		req_type    = REQ_PUT;
		char_code   = '0;
		cell_index  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zeroed store, index edges, ignored code, byte edges, clear
		issue_request(REQ_READ, 8'h00, 11'd0);
		issue_request(REQ_READ, 8'hff, 11'd1999);
		issue_request(REQ_READ, 8'h00, 11'd2000);
		issue_request(REQ_READ, 8'hff, 11'h7ff);
		issue_request(REQ_UNUSED, 8'hff, 11'h7ff);
		issue_request(REQ_PUT, 8'h00, 11'h7ff);
		issue_request(REQ_PUT, 8'hff, 11'd0);
		issue_request(REQ_PUT, 8'h09, 11'd0);
		issue_request(REQ_PUT, 8'h0b, 11'd0);
		issue_request(REQ_PUT, NEWLINE_BYTE, 11'd0);
		issue_request(REQ_PUT, 8'h41, 11'd0);
		issue_request(REQ_READ, 8'h00, 11'd0);
		issue_request(REQ_READ, 8'h00, 11'd3);
		issue_request(REQ_READ, 8'h00, 11'd4);
		issue_request(REQ_READ, 8'h00, 11'd80);
		issue_request(REQ_CLEAR, 8'h00, 11'd0);
		issue_request(REQ_READ, 8'h00, 11'd0);
		issue_request(REQ_READ, 8'h00, 11'd1999);
		issue_request(REQ_UNUSED, 8'h00, 11'd0);
		drain_results();

		// random phases, each under its own attribute, extremes first
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				attr_value = 8'hff;
			else if (phase == 1)
				attr_value = 8'h00;
			else
				attr_value = CHAR_W'($urandom_range(0, 255));
			write_attribute(attr_value);
			// clear after the attribute change so the whole screen holds the new blank
			if (phase == 1)
				issue_request(REQ_CLEAR, 8'h00, 11'd0);
			repeat (PHASE_REQUESTS) random_request();
			drain_results();
		end

		// let any late or spurious result show up before the verdict
		repeat (2100) @(posedge clk);
		$display("run: %0d requests under %0d attribute settings, %0d results checked",
			requests_sent, attribute_writes + 1, results_checked);
		$display("run: %0d scrolls, %0d clears, %0d long result hold-offs",
			scroll_count, clear_count, long_holds);
		if (results_pending != 0)
			$display("%0d expected results never arrived", results_pending);
		if (mismatch_count == 0 && results_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
